// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/fmul_pkg.sv
`default_nettype none
package fmul_pkg;
    localparam int LimbW = 52;
    localparam int WideW = 56;
    localparam int TopW = 49;
    localparam int HalfW = 28;
    localparam int HalfProdW = 56;
    localparam logic [9:0] FoldLow = 10'h3D1;
    localparam logic [63:0] LimbMask = 64'hFFFFFFFFFFFFF;
    localparam logic [63:0] FoldR = 64'h1000003D10;
    localparam logic [63:0] FoldRShr4 = 64'h1000003D1;
    localparam logic [63:0] FoldRShl12 = 64'h1000003D10000;

    typedef struct packed {
        logic [WideW-1:0] a0, a1, a2, a3;
        logic [LimbW-1:0] a4;
        logic [WideW-1:0] b0, b1, b2, b3;
        logic [LimbW-1:0] b4;
    } fmul_in_t;

    typedef struct packed {
        logic [LimbW-1:0] p0, p1, p2, p3;
        logic [TopW-1:0] p4;
    } fmul_out_t;
endpackage
`default_nettype wire

// File: hw/rtl/fmul_if.sv
`default_nettype none
interface fmul_in_if;
    logic valid;
    logic ready;
    fmul_pkg::fmul_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fmul_out_if;
    logic valid;
    logic ready;
    fmul_pkg::fmul_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/fmul_stage_mul.sv
`default_nettype none
// First stage: every limb product split into four 28x28 half-limb products, registered.
module fmul_stage_mul (
    input  wire logic clk,
    input  wire logic en,
    input  wire fmul_pkg::fmul_in_t din,
    output logic [fmul_pkg::HalfProdW-1:0] pp_reg [5][5][4]
);
    import fmul_pkg::*;
    logic [WideW-1:0] av [5];
    logic [WideW-1:0] bv [5];

    always_comb
    begin
        av[0] = din.a0; av[1] = din.a1; av[2] = din.a2; av[3] = din.a3;
        av[4] = {{(WideW-LimbW){1'b0}}, din.a4};
        bv[0] = din.b0; bv[1] = din.b1; bv[2] = din.b2; bv[3] = din.b3;
        bv[4] = {{(WideW-LimbW){1'b0}}, din.b4};
    end

    // Index 0 is low x low, 1 is low x high, 2 is high x low and 3 is high x high.
    // Product registers hold payload only; no reset needed.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 5; i++)
                for (int j = 0; j < 5; j++)
                begin
                    pp_reg[i][j][0] <= HalfProdW'(av[i][HalfW-1:0])
                                     * HalfProdW'(bv[j][HalfW-1:0]);
                    pp_reg[i][j][1] <= HalfProdW'(av[i][HalfW-1:0])
                                     * HalfProdW'(bv[j][WideW-1:HalfW]);
                    pp_reg[i][j][2] <= HalfProdW'(av[i][WideW-1:HalfW])
                                     * HalfProdW'(bv[j][HalfW-1:0]);
                    pp_reg[i][j][3] <= HalfProdW'(av[i][WideW-1:HalfW])
                                     * HalfProdW'(bv[j][WideW-1:HalfW]);
                end
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/field_mul_mod_p_5x52_core.sv
`default_nettype none
// Pipelined secp256k1 field multiplier, 5x52 limbs, weakly reduced result.
// One beat is accepted every cycle while in_ch.ready is high, and a beat passes
// through eleven register stages before the last one offers it. Stage 1 forms
// the 100 half-limb products, stage 2 the three lane sums per column, stage 3
// the column sums, and stages 4 to 10 run the carry and fold chain, one fold or
// one carry step each. Stage 11 forms the top limb. A stall freezes all stages
// together, so input ready drops only while the last stage holds a result that
// the sink has not taken.
module field_mul_mod_p_5x52_core (
    input wire logic clk,
    input wire logic rst_n,
    fmul_in_if.sink in_ch,
    fmul_out_if.source out_ch
);
    import fmul_pkg::*;
    `include "assert_macros.svh"

    localparam int Stages = 11;
    localparam int FoldStages = 7;

    typedef struct packed {
        logic [8:0][127:0] col;
        logic [127:0] c;
        logic [127:0] d;
        logic [127:0] f;
        logic [51:0] t3;
        logic [47:0] t4;
        logic [55:0] u0;
        logic [51:0] r0;
        logic [51:0] r1;
        logic [51:0] r2;
    } fold_t;

    // Multiply by 0x1000003D1 shifted left by sh, as two shifted terms.
    function automatic logic [127:0] mul_fold(input logic [63:0] x, input int sh);
        logic [127:0] xw;
        logic [73:0] xs;
        xw = {64'd0, x};
        xs = 74'(x) * 74'(FoldLow);
        return (xw << (32 + sh)) + ({54'd0, xs} << sh);
    endfunction

    logic [Stages-1:0] vld_reg;
    logic en;
    assign en = !vld_reg[Stages-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Stages-2:0], in_ch.valid};
    end

    // Stage 1: half-limb products.
    logic [HalfProdW-1:0] pp [5][5][4];
    fmul_stage_mul u_mul (.clk(clk), .en(en), .din(in_ch.data), .pp_reg(pp));

    // Stage 2: per column, the low, middle and high lane sums.
    logic [63:0] lane_reg [9][3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                logic [63:0] ll, md, hh;
                ll = '0;
                md = '0;
                hh = '0;
                for (int i = 0; i < 5; i++)
                    for (int j = 0; j < 5; j++)
                        if (i + j == k)
                        begin
                            ll = ll + 64'(pp[i][j][0]);
                            md = md + 64'(pp[i][j][1]) + 64'(pp[i][j][2]);
                            hh = hh + 64'(pp[i][j][3]);
                        end
                lane_reg[k][0] <= ll;
                lane_reg[k][1] <= md;
                lane_reg[k][2] <= hh;
            end
        end
    end

    // Stage 3: column sums (column k = sum over i+j=k).
    logic [8:0][127:0] col_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
                col_reg[k] <= {64'd0, lane_reg[k][0]} + ({64'd0, lane_reg[k][1]} << 28)
                            + ({64'd0, lane_reg[k][2]} << 56);
        end
    end

    // Stages 4 to 10: carry and fold chain, one step per stage.
    fold_t fold_reg [FoldStages];
    fold_t fold_next [FoldStages];
    always_comb
    begin
        logic [127:0] d5;
        // Column 8 low half folded into column 3, high half prepared for column 4.
        fold_next[0] = '0;
        fold_next[0].col = col_reg;
        fold_next[0].d = col_reg[3] + mul_fold(col_reg[8][63:0], 4);
        fold_next[0].f = mul_fold(col_reg[8][127:64], 16);

        // Limb 3 low part split off, column 4 added.
        fold_next[1] = fold_reg[0];
        fold_next[1].t3 = fold_reg[0].d[51:0];
        fold_next[1].d = (fold_reg[0].d >> 52) + fold_reg[0].col[4] + fold_reg[0].f;

        // Limb 4 split into 48 bits and a 4-bit spill, column 5 added.
        fold_next[2] = fold_reg[1];
        fold_next[2].t4 = fold_reg[1].d[47:0];
        d5 = (fold_reg[1].d >> 52) + fold_reg[1].col[5];
        fold_next[2].u0 = {d5[51:0], fold_reg[1].d[51:48]};
        fold_next[2].d = d5 >> 52;

        // Column 5 folded into column 0, column 6 added.
        fold_next[3] = fold_reg[2];
        fold_next[3].c = fold_reg[2].col[0] + mul_fold({8'd0, fold_reg[2].u0}, 0);
        fold_next[3].d = fold_reg[2].d + fold_reg[2].col[6];

        // Limb 0 out, column 6 folded into column 1, column 7 added.
        fold_next[4] = fold_reg[3];
        fold_next[4].r0 = fold_reg[3].c[51:0];
        fold_next[4].c = (fold_reg[3].c >> 52) + fold_reg[3].col[1]
                       + mul_fold({12'd0, fold_reg[3].d[51:0]}, 4);
        fold_next[4].d = (fold_reg[3].d >> 52) + fold_reg[3].col[7];

        // Limb 1 out, column 7 folded into column 2.
        fold_next[5] = fold_reg[4];
        fold_next[5].r1 = fold_reg[4].c[51:0];
        fold_next[5].c = (fold_reg[4].c >> 52) + fold_reg[4].col[2]
                       + mul_fold(fold_reg[4].d[63:0], 4);
        fold_next[5].f = mul_fold(fold_reg[4].d[127:64], 16);

        // Limb 2 out, last fold and limb 3 low part added.
        fold_next[6] = fold_reg[5];
        fold_next[6].r2 = fold_reg[5].c[51:0];
        fold_next[6].c = (fold_reg[5].c >> 52) + fold_reg[5].f + {76'd0, fold_reg[5].t3};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < FoldStages; s++)
                fold_reg[s] <= fold_next[s];
        end
    end

    // Stage 11: limb 3 out and the top limb finalized.
    fmul_out_t res_reg;
    logic [63:0] l4;
    assign l4 = fold_reg[FoldStages-1].c[115:52] + {16'd0, fold_reg[FoldStages-1].t4};
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.p0 <= fold_reg[FoldStages-1].r0;
            res_reg.p1 <= fold_reg[FoldStages-1].r1;
            res_reg.p2 <= fold_reg[FoldStages-1].r2;
            res_reg.p3 <= fold_reg[FoldStages-1].c[51:0];
            res_reg.p4 <= l4[TopW-1:0];
        end
    end

    assign out_ch.valid = vld_reg[Stages-1];
    assign out_ch.data = res_reg;

    `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
    `ASSERT_IMPL(a_ready_when_free, clk, rst_n, !out_ch.valid, in_ch.ready)
    `ASSERT_NEXT(a_enter_tracks, clk, rst_n, in_ch.valid && in_ch.ready, vld_reg[0])
endmodule
`default_nettype wire

// File: bench/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fmul_pkg::*;

    localparam int PipeDepth = 11;
    localparam int CycleLimit = 200000;

    logic clk;
    logic rst_n;

    fmul_in_if in_ch();
    fmul_out_if out_ch();

    field_mul_mod_p_5x52_core u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    // Operand beats waiting to be offered, and products waiting to come out.
    fmul_in_t pending_operands[$];
    fmul_out_t expected_products[$];
    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int cycles = 0;
    bit stimulus_done = 0;
    bit quiet_phase = 0;
    bit hold_off = 0;
    bit in_taken = 0;

    // Predict the weakly reduced product, one column at a time.
    function automatic fmul_out_t predict_product(fmul_in_t x);
        logic [127:0] c, d;
        logic [63:0] t3, t4, tx, u0, hi;
        fmul_out_t r;
        logic [63:0] a[5], b[5];
        a[0] = 64'(x.a0); a[1] = 64'(x.a1); a[2] = 64'(x.a2); a[3] = 64'(x.a3);
        a[4] = 64'(x.a4);
        b[0] = 64'(x.b0); b[1] = 64'(x.b1); b[2] = 64'(x.b2); b[3] = 64'(x.b3);
        b[4] = 64'(x.b4);
        // Column 3 with the low half of column 8 folded.
        d = 128'(a[0]) * b[3] + 128'(a[1]) * b[2] + 128'(a[2]) * b[1] + 128'(a[3]) * b[0];
        c = 128'(a[4]) * b[4];
        d = d + 128'(FoldR) * c[63:0];
        hi = c[127:64];
        t3 = d[63:0] & LimbMask;
        d = d >> 52;
        // Column 4 with the high half of column 8 folded.
        d = d + 128'(a[0]) * b[4] + 128'(a[1]) * b[3] + 128'(a[2]) * b[2]
              + 128'(a[3]) * b[1] + 128'(a[4]) * b[0] + 128'(FoldRShl12) * hi;
        t4 = d[63:0] & LimbMask;
        d = d >> 52;
        tx = t4 >> 48;
        t4 = t4 & (LimbMask >> 4);
        // Column 0 with column 5 folded.
        d = d + 128'(a[1]) * b[4] + 128'(a[2]) * b[3] + 128'(a[3]) * b[2] + 128'(a[4]) * b[1];
        u0 = d[63:0] & LimbMask;
        d = d >> 52;
        u0 = (u0 << 4) | tx;
        c = 128'(a[0]) * b[0] + 128'(u0) * FoldRShr4;
        r.p0 = c[LimbW-1:0];
        c = c >> 52;
        // Column 1 with column 6 folded.
        c = c + 128'(a[0]) * b[1] + 128'(a[1]) * b[0];
        d = d + 128'(a[2]) * b[4] + 128'(a[3]) * b[3] + 128'(a[4]) * b[2];
        c = c + 128'(d[63:0] & LimbMask) * FoldR;
        d = d >> 52;
        r.p1 = c[LimbW-1:0];
        c = c >> 52;
        // Column 2 with column 7 folded.
        c = c + 128'(a[0]) * b[2] + 128'(a[1]) * b[1] + 128'(a[2]) * b[0];
        d = d + 128'(a[3]) * b[4] + 128'(a[4]) * b[3];
        c = c + 128'(FoldR) * d[63:0];
        hi = d[127:64];
        r.p2 = c[LimbW-1:0];
        c = c >> 52;
        // Columns 3 and 4.
        c = c + 128'(FoldRShl12) * hi + t3;
        r.p3 = c[LimbW-1:0];
        c = c >> 52;
        hi = c[63:0] + t4;
        r.p4 = hi[TopW-1:0];
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Limb value biased toward extremes so carries and all bits get exercised.
    function automatic logic [WideW-1:0] pick_limb(int w);
        logic [63:0] m, v;
        m = (64'd1 << w) - 1;
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = m;
            2: v = m - ($urandom_range(0, 15));
            3: v = 64'd1 << $urandom_range(0, w - 1);
            default: v = rand64();
        endcase
        return WideW'(v & m);
    endfunction

    function automatic fmul_in_t random_operands();
        fmul_in_t x;
        x.a0 = pick_limb(WideW); x.a1 = pick_limb(WideW);
        x.a2 = pick_limb(WideW); x.a3 = pick_limb(WideW);
        x.a4 = LimbW'(pick_limb(LimbW));
        x.b0 = pick_limb(WideW); x.b1 = pick_limb(WideW);
        x.b2 = pick_limb(WideW); x.b3 = pick_limb(WideW);
        x.b4 = LimbW'(pick_limb(LimbW));
        return x;
    endfunction

    function automatic fmul_in_t uniform_operands(logic [WideW-1:0] v56, logic [LimbW-1:0] v52,
                                                  logic [WideW-1:0] w56, logic [LimbW-1:0] w52);
        fmul_in_t x;
        x.a0 = v56; x.a1 = v56; x.a2 = v56; x.a3 = v56; x.a4 = v52;
        x.b0 = w56; x.b1 = w56; x.b2 = w56; x.b3 = w56; x.b4 = w52;
        return x;
    endfunction

    always #5 clk = ~clk;

    // Stimulus: directed extremes, then random beats, squares among them.
    initial
    begin
        fmul_in_t x;
        logic [WideW-1:0] m56;
        logic [LimbW-1:0] m52;
        m56 = '1;
        m52 = '1;
        pending_operands.push_back(uniform_operands('0, '0, '0, '0));
        pending_operands.push_back(uniform_operands(m56, m52, m56, m52));
        pending_operands.push_back(uniform_operands(m56, m52, '0, '0));
        pending_operands.push_back(uniform_operands(56'd1, 52'd0, m56, m52));
        pending_operands.push_back(uniform_operands(56'hFFFFFFFFFFFFF, m52, 56'hFFFFFFFFFFFFF, m52));
        // The prime itself, and p - 1 squared.
        x = uniform_operands(56'hFFFFFFFFFFFFF, 52'hFFFFFFFFFFFF, 56'd0, 52'd0);
        x.a0 = 56'hFFFFEFFFFFC2F;
        x.b0 = 56'd1;
        pending_operands.push_back(x);
        x.a0 = 56'hFFFFEFFFFFC2E;
        {x.b0, x.b1, x.b2, x.b3, x.b4} = {x.a0, x.a1, x.a2, x.a3, x.a4};
        pending_operands.push_back(x);
        for (int i = 0; i < 10; i++)
        begin
            x = uniform_operands('0, '0, '0, '0);
            case (i % 5)
                0: begin x.a0 = m56; x.b4 = m52; end
                1: begin x.a4 = m52; x.b4 = m52; end
                2: begin x.a3 = m56; x.b3 = m56; end
                3: begin x.a1 = m56; x.b4 = m52; end
                default: begin x.a2 = m56; x.b2 = m56; end
            endcase
            if (i >= 5)
            begin
                x.a0 = m56;
                x.b0 = m56;
            end
            pending_operands.push_back(x);
        end
        for (int i = 0; i < 550; i++)
        begin
            x = random_operands();
            if ($urandom_range(0, 4) == 0)
                {x.b0, x.b1, x.b2, x.b3, x.b4} = {x.a0, x.a1, x.a2, x.a3, x.a4};
            pending_operands.push_back(x);
        end
    end

    // Reset and end of run.
    initial
    begin
        clk = 0;
        rst_n = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        wait (pending_operands.size() == 0 && stimulus_done);
        wait (expected_products.size() == 0);
        repeat (PipeDepth * 4) @(posedge clk);
        $display("Checked %0d products from %0d operand beats, including squares,",
                 beats_out, beats_in);
        $display("limb extremes and a long output stall that backed up the pipeline.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Input sampling: an operand beat is taken at a rising edge with valid and ready high.
    always @(posedge clk)
    begin
        in_taken = 0;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            expected_products.push_back(predict_product(in_ch.data));
            beats_in <= beats_in + 1;
            void'(pending_operands.pop_front());
            in_taken = 1;
        end
    end

    // Sender: offers beats from the queue, with bursts of idle cycles.
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            quiet_phase <= (pending_operands.size() < 80);
            if (in_ch.valid && !in_taken)
            begin
                // Keep offering the same beat.
            end
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 0;
            end
            else if (pending_operands.size() > 0)
            begin
                if (!quiet_phase && $urandom_range(0, 5) == 0)
                begin
                    send_gap <= $urandom_range(0, 2);
                    in_ch.valid <= 0;
                end
                else
                begin
                    in_ch.valid <= 1;
                    in_ch.data <= pending_operands[0];
                end
            end
            else
            begin
                in_ch.valid <= 0;
                stimulus_done <= 1;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off early in the run.
    int stall_gap = 0;
    int hold_count = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (beats_in == 100 && hold_count == 0 && !hold_off)
            begin
                hold_off <= 1;
                hold_count <= 1;
                out_ch.ready <= 0;
            end
            else if (hold_off)
            begin
                hold_count <= hold_count + 1;
                if (hold_count >= 60)
                    hold_off <= 0;
                out_ch.ready <= 0;
            end
            else if (stall_gap > 0)
            begin
                stall_gap <= stall_gap - 1;
                out_ch.ready <= 0;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                stall_gap <= $urandom_range(0, 2);
                out_ch.ready <= 0;
            end
            else
                out_ch.ready <= 1;
        end
    end

    // Monitor: compares each product beat against the oldest prediction.
    always @(posedge clk)
    begin
        fmul_out_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            beats_out <= beats_out + 1;
            if (expected_products.size() == 0)
            begin
                $error("product beat with no prediction pending");
                errors = errors + 1;
            end
            else
            begin
                want = expected_products.pop_front();
                if (out_ch.data.p0 !== want.p0)
                begin
                    $error("prod_limb0 expected %h got %h", want.p0, out_ch.data.p0);
                    errors = errors + 1;
                end
                if (out_ch.data.p1 !== want.p1)
                begin
                    $error("prod_limb1 expected %h got %h", want.p1, out_ch.data.p1);
                    errors = errors + 1;
                end
                if (out_ch.data.p2 !== want.p2)
                begin
                    $error("prod_limb2 expected %h got %h", want.p2, out_ch.data.p2);
                    errors = errors + 1;
                end
                if (out_ch.data.p3 !== want.p3)
                begin
                    $error("prod_limb3 expected %h got %h", want.p3, out_ch.data.p3);
                    errors = errors + 1;
                end
                if (out_ch.data.p4 !== want.p4)
                begin
                    $error("prod_limb4 expected %h got %h", want.p4, out_ch.data.p4);
                    errors = errors + 1;
                end
            end
        end
    end
endmodule
`default_nettype wire
